// ===== rtl/core/apc_pkg.sv =====
// shared constants, state encoding and interface structs for the amicable pair checker
`default_nettype none

package apc_pkg;

   // width of the tested number
   localparam int CANDIDATE_BITS = 30;
   // width of the aliquot sum field on the result channel
   localparam int SUM_OUT_BITS = 33;
   // working width of a value whose divisors are summed (candidate or its sum)
   localparam int VAL_BITS = CANDIDATE_BITS + 3;
   // divisor sums of a working value, wide enough for the second pass
   localparam int ACC_BITS = VAL_BITS + 3;
   // trial divisors stop just above the square root of a working value
   localparam int DIV_BITS = (VAL_BITS + 1) / 2 + 1;
   // bit length of a divisor and divider step counts
   localparam int LEN_BITS = $clog2(VAL_BITS + 1);
   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_BITS = ((CANDIDATE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((SUM_OUT_BITS + 1 + 7) / 8) * 8;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_INIT,
      SEQ_START,
      SEQ_WAIT,
      SEQ_CHECK,
      SEQ_ADD_Q,
      SEQ_PASS_END,
      SEQ_DONE
   } apc_seq_state_type;

   typedef struct packed {
      logic                start;
      logic [VAL_BITS-1:0] dividend;
      logic [DIV_BITS-1:0] divisor;
      logic [LEN_BITS-1:0] divisor_len;
   } apc_div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [VAL_BITS-1:0] quotient;
      logic [VAL_BITS-1:0] remainder;
   } apc_div_rsp_type;

   typedef struct packed {
      logic                load;
      logic [VAL_BITS-1:0] aliquot_sum;
      logic                is_amicable;
   } apc_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/amicable_pair_checker.sv =====
// top level of the amicable pair checker: stream ports, sequencer, divider, result register
`default_nettype none

// Takes one candidate n per transfer and returns one result: the sum s of the
// proper divisors of n (0 for n of zero or one) and a flag that is set when
// s > n and the proper divisor sum of s equals n, i.e. n is the smaller member
// of an amicable pair with partner s. Divisors are found by trial division with
// d = 2, 3, ... until the quotient drops below d, first over n and, when s > n,
// over s. One item at a time: req_tready is high only while the block is idle.
// Each trial divisor costs one run of the shift-subtract divider, which both
// passes share, plus the sequencer states that start it and check its result.
// The finished result sits in an output register, so a new candidate is taken
// as soon as the previous result is loaded there, even while the consumer
// stalls.
module amicable_pair_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // candidate [29:0], zero padding above
   input  logic [apc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // aliquot_sum [32:0], is_amicable [33], zero padding above
   output logic [apc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import apc_pkg::*;

   apc_div_req_type          div_req;
   apc_div_rsp_type          div_rsp;
   apc_result_type           result;
   logic                     seq_idle;
   logic                     req_xfer;
   logic                     out_free;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // input transfer only while the sequencer is idle
   assign req_tready = seq_idle;
   assign req_xfer   = req_tvalid && req_tready;

   // output slot is free when empty or being emptied this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   apc_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (req_xfer),
      .candidate (req_tdata[CANDIDATE_BITS-1:0]),
      .out_free  (out_free),
      .div_rsp   (div_rsp),
      .div_req   (div_req),
      .result    (result),
      .idle      (seq_idle)
   );

   apc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // result register on the output side
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (result.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_BITS'({result.is_amicable,
                                        SUM_OUT_BITS'(result.aliquot_sum)});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // an accepted candidate keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input accepted twice in a row");

   // a result never overwrites one that has not been transferred
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded into an occupied output register");

   // the divider is started only when it has finished its previous run
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (!div_rsp.busy && !div_rsp.done))
      else $error("divider started while busy");

   // no divider activity while the sequencer waits for a new candidate
   a_div_quiet_when_idle: assert property (@(posedge clock) disable iff (reset)
      seq_idle |-> !div_rsp.busy)
      else $error("divider running while sequencer idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/apc_divider.sv =====
// shift-subtract divider, one quotient bit per cycle, skipping bits known to be zero
`default_nettype none

module apc_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  apc_pkg::apc_div_req_type div_req,
   output apc_pkg::apc_div_rsp_type div_rsp
);
   import apc_pkg::*;

   localparam int PR_BITS = 2 * VAL_BITS;

   logic [PR_BITS-1:0]  pr_ff, pr_in;
   logic [VAL_BITS-1:0] divisor_ff, divisor_in;
   logic [LEN_BITS-1:0] count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [PR_BITS-1:0]  pr_load;
   logic [VAL_BITS:0]   trial;
   logic [VAL_BITS+1:0] diff;

   // partial remainder in the upper half, dividend bits then quotient bits in the lower half
   always_comb begin
      pr_load    = PR_BITS'(div_req.dividend) << (div_req.divisor_len - LEN_BITS'(1));
      trial      = {pr_ff[PR_BITS-1:VAL_BITS], pr_ff[VAL_BITS-1]};
      diff       = {1'b0, trial} - {2'b00, divisor_ff};
      pr_in      = pr_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         pr_in      = pr_load;
         divisor_in = VAL_BITS'(div_req.divisor);
         // quotient cannot reach above bit VAL_BITS - divisor_len
         count_in   = LEN_BITS'(VAL_BITS) - div_req.divisor_len + LEN_BITS'(1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (diff[VAL_BITS+1]) begin
            pr_in = {trial[VAL_BITS-1:0], pr_ff[VAL_BITS-2:0], 1'b0};
         end else begin
            pr_in = {diff[VAL_BITS-1:0], pr_ff[VAL_BITS-2:0], 1'b1};
         end
         count_in = count_ff - LEN_BITS'(1);
         if (count_ff == LEN_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pr_ff      <= pr_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = pr_ff[VAL_BITS-1:0];
   assign div_rsp.remainder = pr_ff[PR_BITS-1:VAL_BITS];

endmodule

`default_nettype wire

// ===== rtl/core/apc_sequencer.sv =====
// trial division sequencer: walks divisors, sums them, reruns on the sum if it exceeds n
`default_nettype none

module apc_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [apc_pkg::CANDIDATE_BITS-1:0]   candidate,
   input  logic                                 out_free,
   input  apc_pkg::apc_div_rsp_type             div_rsp,
   output apc_pkg::apc_div_req_type             div_req,
   output apc_pkg::apc_result_type              result,
   output logic                                 idle
);
   import apc_pkg::*;

   apc_seq_state_type         state_ff, state_in;
   logic [CANDIDATE_BITS-1:0] n_ff, n_in;
   logic [VAL_BITS-1:0]       v_ff, v_in;
   logic [VAL_BITS-1:0]       sum_ff, sum_in;
   logic [DIV_BITS-1:0]       d_ff, d_in;
   logic [LEN_BITS-1:0]       dlen_ff, dlen_in;
   logic [ACC_BITS-1:0]       total_ff, total_in;
   logic                      pass_ff, pass_in;
   logic                      flag_ff, flag_in;
   logic [DIV_BITS-1:0]       d_next;
   logic                      q_below_d;
   logic                      q_is_d;
   logic                      divides;
   logic                      total_above_n;
   logic                      value_small;

   always_comb begin
      d_next        = d_ff + DIV_BITS'(1);
      q_below_d     = div_rsp.quotient < VAL_BITS'(d_ff);
      q_is_d        = div_rsp.quotient == VAL_BITS'(d_ff);
      divides       = div_rsp.remainder == '0;
      total_above_n = total_ff > ACC_BITS'(n_ff);
      value_small   = v_ff < VAL_BITS'(2);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE:     if (start) state_in = SEQ_INIT;
         SEQ_INIT:     state_in = value_small ? SEQ_PASS_END : SEQ_START;
         SEQ_START:    state_in = SEQ_WAIT;
         SEQ_WAIT:     if (div_rsp.done) state_in = SEQ_CHECK;
         SEQ_CHECK: begin
            // quotient below divisor means the divisor passed the square root
            if (q_below_d) state_in = SEQ_PASS_END;
            else if (divides && !q_is_d) state_in = SEQ_ADD_Q;
            else state_in = SEQ_START;
         end
         SEQ_ADD_Q:    state_in = SEQ_START;
         SEQ_PASS_END: state_in = (!pass_ff && total_above_n) ? SEQ_INIT : SEQ_DONE;
         SEQ_DONE:     if (out_free) state_in = SEQ_IDLE;
         default:      state_in = SEQ_IDLE;
      endcase
   end

   // datapath updates and outputs
   always_comb begin
      n_in     = n_ff;
      v_in     = v_ff;
      sum_in   = sum_ff;
      d_in     = d_ff;
      dlen_in  = dlen_ff;
      total_in = total_ff;
      pass_in  = pass_ff;
      flag_in  = flag_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               n_in    = candidate;
               v_in    = VAL_BITS'(candidate);
               pass_in = 1'b0;
            end
         end
         SEQ_INIT: begin
            total_in = value_small ? '0 : ACC_BITS'(1);
            d_in     = DIV_BITS'(2);
            dlen_in  = LEN_BITS'(2);
         end
         SEQ_CHECK: begin
            if (!q_below_d) begin
               if (divides) total_in = total_ff + ACC_BITS'(d_ff);
               d_in = d_next;
               // bit length grows when the new divisor is a power of two
               if ((d_next & d_ff) == '0) dlen_in = dlen_ff + LEN_BITS'(1);
            end
         end
         SEQ_ADD_Q:    total_in = total_ff + ACC_BITS'(div_rsp.quotient);
         SEQ_PASS_END: begin
            if (!pass_ff) begin
               sum_in  = VAL_BITS'(total_ff);
               v_in    = VAL_BITS'(total_ff);
               flag_in = 1'b0;
               pass_in = total_above_n;
            end else begin
               flag_in = total_ff == ACC_BITS'(n_ff);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      div_req.start       = state_ff == SEQ_START;
      div_req.dividend    = v_ff;
      div_req.divisor     = d_ff;
      div_req.divisor_len = dlen_ff;
      result.load         = (state_ff == SEQ_DONE) && out_free;
      result.aliquot_sum  = sum_ff;
      result.is_amicable  = flag_ff;
      idle                = state_ff == SEQ_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      v_ff     <= v_in;
      sum_ff   <= sum_in;
      d_ff     <= d_in;
      dlen_ff  <= dlen_in;
      total_ff <= total_in;
      pass_ff  <= pass_in;
      flag_ff  <= flag_in;
   end

endmodule

`default_nettype wire
